/* design/uniform_grid_box_index_core_assert.svh */
// assertion macros for the uniform grid box index core
// expects clk and rst_n in the scope of use
`ifndef UNIFORM_GRID_BOX_INDEX_CORE_ASSERT_SVH
`define UNIFORM_GRID_BOX_INDEX_CORE_ASSERT_SVH

// same-cycle implication
`define UGBI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UGBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ugbi_pkg.sv */
// shared types and codes of the uniform grid box index
// no dependencies
`default_nettype none

package ugbi_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_INV_X    = 3'd2;
  localparam logic [2:0] REG_INV_Y    = 3'd3;
  localparam logic [2:0] REG_CELLS_X  = 3'd4;
  localparam logic [2:0] REG_CELLS_Y  = 3'd5;

  localparam int AXIS_MAX = 256;

  typedef struct packed {
    logic [1:0] op;
    logic       ok;
    logic       full;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] y0;
    logic [7:0] y1;
    logic [8:0] cx;
  } cmd_t;

endpackage

`default_nettype wire

/* design/ugbi_ifs.sv */
// channel interfaces of the uniform grid box index: request, answer, register write
// no dependencies
`default_nettype none

interface ugbi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] coord_x0;
  logic signed [31:0] coord_y0;
  logic signed [31:0] coord_x1;
  logic signed [31:0] coord_y1;
  modport source (output valid, req_type, coord_x0, coord_y0, coord_x1, coord_y1,
                  input ready);
  modport sink (input valid, req_type, coord_x0, coord_y0, coord_x1, coord_y1,
                output ready);
endinterface

interface ugbi_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_index;
  logic [63:0] item_mask;
  logic        last;
  modport source (output valid, word_index, item_mask, last, input ready);
  modport sink (input valid, word_index, item_mask, last, output ready);
endinterface

interface ugbi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/uniform_grid_box_index_core.sv */
// top level of the uniform grid box index: front, command queue, back
// depends on ugbi_pkg, ugbi_ifs, ugbi_front, ugbi_cmd_q, ugbi_back and the assert header
//
// channel  | dir | transaction
// in_ch    | in  | req_type, coord_x0/y0/x1/y1 (insert box, query rectangle, clear)
// out_ch   | out | word_index, item_mask, last (one answer word)
// cfg_ch   | in  | index, data (register write, always ready)
//
// front: accept, divider steps, grid clamp, multiply and evaluate per cell bound,
//   area, grid size, push
// insert: setup, then a store read-modify-write per covered cell
// query: setup, then per 64-item word a store read per covered cell and a word step,
//   or the word step alone at a quarter of the grid or more; then the final word
// reset and clear: sweep of MAX_CELLS*WORDS store entries, one per cycle; in_ch stalls
//   during the sweep; a stalled out_ch holds the back, the queue lets the front run ahead
`default_nettype none
`include "uniform_grid_box_index_core_assert.svh"

module uniform_grid_box_index_core import ugbi_pkg::*; #(
  parameter int MAX_CELLS = 256,
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ugbi_in_if.sink    in_ch,
  ugbi_out_if.source out_ch,
  ugbi_cfg_if.sink   cfg_ch
);

  logic sweep_busy;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_din, q_dout;

  ugbi_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .sweep_busy (sweep_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_din)
  );

  ugbi_cmd_q u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  ugbi_back #(.MAX_CELLS(MAX_CELLS), .MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_dout),
    .q_pop      (q_pop),
    .sweep_busy (sweep_busy),
    .out_ch     (out_ch)
  );

  `UGBI_ASSERT_IMPL(a_no_accept_in_sweep, sweep_busy, !(in_ch.valid && in_ch.ready), "transaction accepted during store sweep")
  `UGBI_ASSERT_IMPL(a_no_push_full, q_push, !q_full, "push into full command queue")
  `UGBI_ASSERT_IMPL(a_pop_has_data, q_pop, q_valid, "pop from empty command queue")

endmodule

`default_nettype wire

/* design/ugbi_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ugbi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/ugbi_cmd_q.sv */
// two-entry command queue between front and back
// depends on ugbi_pkg
`default_nettype none

module ugbi_cmd_q import ugbi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      valid
);

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        ent_r[wp_r] <= din;
        wp_r        <= ~wp_r;
      end
      if (pop && valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && valid);
    end
  end

endmodule

`default_nettype wire

/* design/ugbi_front.sv */
// front: register file, request intake, grid size and cell span computation
// depends on ugbi_pkg and ugbi_ifs
`default_nettype none

module ugbi_front import ugbi_pkg::*; #(
  parameter int MAX_CELLS = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ugbi_in_if.sink    in_ch,
  ugbi_cfg_if.sink   cfg_ch,
  input  wire logic  sweep_busy,
  input  wire logic  q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int QW    = $clog2(MAX_CELLS + 1) + 1;
  localparam int SW    = $clog2(QW + 1);
  localparam int LW    = (QW > 9) ? QW : 9;
  localparam int CAP_I = (MAX_CELLS < AXIS_MAX) ? MAX_CELLS : AXIS_MAX;
  localparam logic [8:0]    CAP      = 9'(CAP_I);
  localparam logic [QW-1:0] DIVIDEND = QW'(MAX_CELLS);
  localparam logic [SW-1:0] DIV_LAST = SW'(QW - 1);

  typedef enum logic [2:0] {
    F_IDLE, F_DIV, F_EFF, F_MUL, F_EVAL, F_AREA, F_GRID, F_PUSH
  } fstate_t;

  fstate_t            state_r;
  logic signed [31:0] org_x_r, org_y_r;
  logic [31:0]        inv_x_r, inv_y_r;
  logic [8:0]         cells_x_r, cells_y_r;
  logic [1:0]         op_r;
  logic signed [31:0] ax_r, ay_r, bx_r, by_r;
  logic [7:0]         rem_r;
  logic [QW-1:0]      quo_r;
  logic [QW-1:0]      dsh_r;
  logic [SW-1:0]      step_r;
  logic [8:0]         cx_r, cy_r;
  logic [1:0]         k_r;
  logic [63:0]        prod_r;
  logic               dpos_r;
  logic [7:0]         cell_r [4];
  logic               rej_r;
  logic [17:0]        area_r, grid_r;

  logic [8:0]         cx_c, cy_c;
  logic [8:0]         trial;
  logic               ge;
  logic signed [31:0] ia, ib, org, lo, hi, v;
  logic [31:0]        inv;
  logic [8:0]         cells;
  logic [7:0]         last_c, cellv;
  logic signed [32:0] d;
  logic               dpos, rej_static, over;
  logic [63:0]        prod_c;
  logic [7:0]         x1f, y1f;
  logic               in_ready;

  assign in_ready     = (state_r == F_IDLE) && !sweep_busy;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cx_c = cells_x_r;
    if (inv_x_r == 32'd0 || cx_c == 9'd0) cx_c = 9'd1;
    if (cx_c > 9'd256) cx_c = 9'd256;
    if (cx_c > CAP) cx_c = CAP;
    cy_c = cells_y_r;
    if (inv_y_r == 32'd0 || cy_c == 9'd0) cy_c = 9'd1;
    if (cy_c > 9'd256) cy_c = 9'd256;
    if (LW'(cy_c) > LW'(quo_r)) cy_c = 9'(quo_r);
    if (cy_c == 9'd0) cy_c = 9'd1;
  end

  assign trial = {rem_r, dsh_r[QW-1]};
  assign ge    = (trial >= cx_c);

  always_comb begin
    ia    = k_r[1] ? ay_r : ax_r;
    ib    = k_r[1] ? by_r : bx_r;
    org   = k_r[1] ? org_y_r : org_x_r;
    inv   = k_r[1] ? inv_y_r : inv_x_r;
    cells = k_r[1] ? cy_r : cx_r;
    if (op_r == REQ_INSERT && ib < ia) begin
      lo = ib;
      hi = ia;
    end else begin
      lo = ia;
      hi = ib;
    end
    v          = k_r[0] ? hi : lo;
    d          = {v[31], v} - {org[31], org};
    dpos       = !d[32] && (d != 33'sd0);
    rej_static = (hi < lo) || (hi < org) || (inv == 32'd0 && lo > org);
    last_c     = 8'(cells - 9'd1);
    over       = dpos_r && ((prod_r[63:32] > 32'(cells)) ||
                 (prod_r[63:32] == 32'(cells) && prod_r[31:0] != 32'd0));
    if (!dpos_r) begin
      cellv = 8'd0;
    end else if (prod_r[63:32] >= 32'(last_c)) begin
      cellv = last_c;
    end else begin
      cellv = prod_r[39:32];
    end
  end

  assign prod_c = d[31:0] * inv;
  assign x1f    = (cell_r[1] < cell_r[0]) ? cell_r[0] : cell_r[1];
  assign y1f    = (cell_r[3] < cell_r[2]) ? cell_r[2] : cell_r[3];

  assign q_push     = (state_r == F_PUSH) && !q_full;
  assign q_cmd.op   = op_r;
  assign q_cmd.ok   = !rej_r;
  assign q_cmd.full = ({area_r, 2'b00} >= {2'b00, grid_r});
  assign q_cmd.x0   = cell_r[0];
  assign q_cmd.x1   = x1f;
  assign q_cmd.y0   = cell_r[2];
  assign q_cmd.y1   = y1f;
  assign q_cmd.cx   = cx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      org_x_r   <= '0;
      org_y_r   <= '0;
      inv_x_r   <= '0;
      inv_y_r   <= '0;
      cells_x_r <= 9'd1;
      cells_y_r <= 9'd1;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_ORIGIN_X: org_x_r   <= cfg_ch.data;
          REG_ORIGIN_Y: org_y_r   <= cfg_ch.data;
          REG_INV_X:    inv_x_r   <= cfg_ch.data;
          REG_INV_Y:    inv_y_r   <= cfg_ch.data;
          REG_CELLS_X:  cells_x_r <= cfg_ch.data[8:0];
          REG_CELLS_Y:  cells_y_r <= cfg_ch.data[8:0];
          default: ;
        endcase
      end
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid && in_ready) begin
            op_r   <= in_ch.req_type;
            ax_r   <= in_ch.coord_x0;
            ay_r   <= in_ch.coord_y0;
            bx_r   <= in_ch.coord_x1;
            by_r   <= in_ch.coord_y1;
            rem_r  <= '0;
            quo_r  <= '0;
            dsh_r  <= DIVIDEND;
            step_r <= '0;
            unique case (in_ch.req_type) inside
              REQ_INSERT, REQ_QUERY: state_r <= F_DIV;
              REQ_CLEAR:             state_r <= F_PUSH;
              default:               state_r <= F_IDLE;
            endcase
          end
        end
        F_DIV: begin
          rem_r  <= ge ? 8'(trial - cx_c) : trial[7:0];
          quo_r  <= {quo_r[QW-2:0], ge};
          dsh_r  <= {dsh_r[QW-2:0], 1'b0};
          step_r <= step_r + SW'(1);
          if (step_r == DIV_LAST) state_r <= F_EFF;
        end
        F_EFF: begin
          cx_r    <= cx_c;
          cy_r    <= cy_c;
          rej_r   <= 1'b0;
          k_r     <= 2'd0;
          state_r <= F_MUL;
        end
        F_MUL: begin
          prod_r <= prod_c;
          dpos_r <= dpos;
          if (op_r == REQ_QUERY && !k_r[0] && rej_static) rej_r <= 1'b1;
          state_r <= F_EVAL;
        end
        F_EVAL: begin
          cell_r[k_r] <= cellv;
          if (op_r == REQ_QUERY && !k_r[0] && over) rej_r <= 1'b1;
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == 2'd3) ? F_AREA : F_MUL;
        end
        F_AREA: begin
          area_r  <= (9'(x1f) - 9'(cell_r[0]) + 9'd1) * (9'(y1f) - 9'(cell_r[2]) + 9'd1);
          state_r <= F_GRID;
        end
        F_GRID: begin
          grid_r  <= cx_r * cy_r;
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/ugbi_back.sv */
// back: cell store sequencer for insert, query and clear, answer output register
// depends on ugbi_pkg, ugbi_ifs and ugbi_ram
`default_nettype none

module ugbi_back import ugbi_pkg::*; #(
  parameter int MAX_CELLS = 256,
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire cmd_t  q_cmd,
  output logic       q_pop,
  output logic       sweep_busy,
  ugbi_out_if.source out_ch
);

  localparam int WORDS = (MAX_ITEMS + 63) / 64;
  localparam int DEPTH = MAX_CELLS * WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [AW-1:0]    WSTEP   = AW'(WORDS);
  localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);
  localparam logic [WW-1:0]    LAST_W  = WW'(WORDS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  typedef enum logic [3:0] {
    B_CLR, B_IDLE, B_SET1, B_SET2, B_IRD, B_IWR, B_QRD, B_QACC, B_QWORD, B_FIN
  } bstate_t;

  bstate_t          state_r;
  cmd_t             cmd_r;
  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0]    clr_a_r;
  logic [16:0]      rowmul_r;
  logic [AW-1:0]    base0_r, stride_r, rowbase_r, cur_r;
  logic [7:0]       x_r, y_r;
  logic [WW-1:0]    w_r;
  logic [63:0]      acc_r;
  logic             pend_v_r;
  logic [3:0]       pend_idx_r;
  logic [63:0]      pend_r;
  logic             out_v_r;
  logic [3:0]       out_idx_r;
  logic [63:0]      out_mask_r;
  logic             out_last_r;

  logic [AW-1:0]    addr_c, base_c;
  logic [63:0]      bit_c, rdata, fmask, val;
  logic             we, re, at_end, out_free, stall, load_out;
  logic [AW-1:0]    waddr;
  logic [63:0]      wdata;

  assign sweep_busy = (state_r == B_CLR);
  assign q_pop      = (state_r == B_IDLE) && q_valid;
  assign out_free   = !out_v_r || out_ch.ready;

  assign addr_c = cur_r + ((state_r == B_IRD || state_r == B_IWR) ?
                  AW'(cnt_r[CNT_W-1:6]) : AW'(w_r));
  assign bit_c  = 64'd1 << cnt_r[5:0];
  assign base_c = AW'((32'(rowmul_r) + 32'(cmd_r.x0)) * WORDS);
  assign at_end = (x_r == cmd_r.x1) && (y_r == cmd_r.y1);

  always_comb begin
    if (32'(w_r) < 32'(cnt_r[CNT_W-1:6])) begin
      fmask = '1;
    end else if (32'(w_r) == 32'(cnt_r[CNT_W-1:6])) begin
      fmask = (64'd1 << cnt_r[5:0]) - 64'd1;
    end else begin
      fmask = '0;
    end
    val   = cmd_r.full ? fmask : acc_r;
    stall = (val != 64'd0) && pend_v_r && !out_free;
  end

  assign load_out = ((state_r == B_QWORD) && !stall && (val != 64'd0) && pend_v_r) ||
                    ((state_r == B_FIN) && out_free);

  assign we    = (state_r == B_CLR) || (state_r == B_IWR);
  assign re    = (state_r == B_IRD) || (state_r == B_QRD);
  assign waddr = (state_r == B_CLR) ? clr_a_r : addr_c;
  assign wdata = (state_r == B_CLR) ? 64'd0 : (rdata | bit_c);

  ugbi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (addr_c),
    .rdata (rdata)
  );

  assign out_ch.valid      = out_v_r;
  assign out_ch.word_index = out_idx_r;
  assign out_ch.item_mask  = out_mask_r;
  assign out_ch.last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLR;
      clr_a_r  <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r) inside
        B_CLR: begin
          clr_a_r <= clr_a_r + AW'(1);
          if (clr_a_r == LAST_A) state_r <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            unique case (q_cmd.op)
              REQ_INSERT: begin
                if (cnt_r < CNT_MAX) state_r <= B_SET1;
              end
              REQ_QUERY: begin
                state_r <= (!q_cmd.ok || cnt_r == '0) ? B_FIN : B_SET1;
              end
              REQ_CLEAR: begin
                cnt_r   <= '0;
                clr_a_r <= '0;
                state_r <= B_CLR;
              end
              default: ;
            endcase
          end
        end
        B_SET1: begin
          rowmul_r <= cmd_r.y0 * cmd_r.cx;
          state_r  <= B_SET2;
        end
        B_SET2: begin
          base0_r   <= base_c;
          rowbase_r <= base_c;
          cur_r     <= base_c;
          stride_r  <= AW'(32'(cmd_r.cx) * WORDS);
          x_r       <= cmd_r.x0;
          y_r       <= cmd_r.y0;
          w_r       <= '0;
          acc_r     <= '0;
          if (cmd_r.op == REQ_INSERT) begin
            state_r <= B_IRD;
          end else begin
            state_r <= cmd_r.full ? B_QWORD : B_QRD;
          end
        end
        B_IRD: state_r <= B_IWR;
        B_QRD: state_r <= B_QACC;
        B_IWR, B_QACC: begin
          if (state_r == B_QACC) acc_r <= acc_r | rdata;
          if (x_r == cmd_r.x1) begin
            x_r       <= cmd_r.x0;
            y_r       <= y_r + 8'd1;
            rowbase_r <= rowbase_r + stride_r;
            cur_r     <= rowbase_r + stride_r;
          end else begin
            x_r   <= x_r + 8'd1;
            cur_r <= cur_r + WSTEP;
          end
          if (state_r == B_IWR) begin
            if (at_end) begin
              cnt_r   <= cnt_r + CNT_W'(1);
              state_r <= B_IDLE;
            end else begin
              state_r <= B_IRD;
            end
          end else begin
            state_r <= at_end ? B_QWORD : B_QRD;
          end
        end
        B_QWORD: begin
          if (!stall) begin
            if (val != 64'd0) begin
              if (pend_v_r) begin
                out_idx_r  <= pend_idx_r;
                out_mask_r <= pend_r;
                out_last_r <= 1'b0;
              end
              pend_v_r   <= 1'b1;
              pend_idx_r <= 4'(w_r);
              pend_r     <= val;
            end
            if (w_r == LAST_W) begin
              state_r <= B_FIN;
            end else begin
              w_r       <= w_r + WW'(1);
              acc_r     <= '0;
              x_r       <= cmd_r.x0;
              y_r       <= cmd_r.y0;
              rowbase_r <= base0_r;
              cur_r     <= base0_r;
              state_r   <= cmd_r.full ? B_QWORD : B_QRD;
            end
          end
        end
        B_FIN: begin
          if (out_free) begin
            out_idx_r  <= pend_v_r ? pend_idx_r : 4'd0;
            out_mask_r <= pend_v_r ? pend_r : 64'd0;
            out_last_r <= 1'b1;
            pend_v_r   <= 1'b0;
            state_r    <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/uniform_grid_box_index_core_test.sv */
// testbench of the uniform grid box index core: predicts every answer word of a query
// from its own grid store and checks the out channel against it
// depends on ugbi_pkg, ugbi_ifs and the core
`timescale 1ns / 1ps

module uniform_grid_box_index_core_test;
  import ugbi_pkg::*;

  typedef struct {
    bit [1:0]         op;
    bit signed [31:0] x0, y0, x1, y1;
  } grid_req_t;

  typedef struct {
    bit [3:0]  word;
    bit [63:0] mask;
    bit        last;
  } answer_word_t;

  class grid_scoreboard;
    bit [63:0]        members[4096];
    int unsigned      count;
    bit signed [31:0] ox, oy;
    bit [31:0]        ix, iy;
    bit [8:0]         ncx, ncy;
    answer_word_t     answers[$];
    int               errors;
    int               words_seen;

    function void set_reg(bit [2:0] idx, bit [31:0] val);
      case (idx)
        REG_ORIGIN_X: ox = val;
        REG_ORIGIN_Y: oy = val;
        REG_INV_X:    ix = val;
        REG_INV_Y:    iy = val;
        REG_CELLS_X:  ncx = val[8:0];
        REG_CELLS_Y:  ncy = val[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned cols();
      int unsigned c;
      c = ncx;
      if (ix == 0 || c == 0) c = 1;
      if (c > 256) c = 256;
      return c;
    endfunction

    function int unsigned rows(int unsigned cx);
      int unsigned c, lim;
      c = ncy;
      lim = 256 / cx;
      if (iy == 0 || c == 0) c = 1;
      if (c > 256) c = 256;
      if (c > lim) c = lim;
      if (c == 0) c = 1;
      return c;
    endfunction

    function int unsigned cell_of(longint v, longint org, bit [31:0] inv, int unsigned cells);
      longint d;
      bit [63:0] du, p;
      if (cells <= 1) return 0;
      d = v - org;
      if (d <= 0 || inv == 0) return 0;
      du = d;
      p = du * {32'd0, inv};
      p = p >> 32;
      if (p >= cells - 1) return cells - 1;
      return 32'(p);
    endfunction

    function bit span_of(longint lo, longint hi, longint org, bit [31:0] inv,
                         int unsigned cells, output int unsigned c0, output int unsigned c1);
      bit [63:0] lastc, t1, p0, du;
      longint d0;
      c0 = 0;
      c1 = 0;
      if (hi < lo || hi < org) return 0;
      if (inv != 0) begin
        lastc = cells - 1;
        d0 = lo - org;
        du = hi - org;
        t1 = (du * {32'd0, inv}) >> 32;
        if (d0 > 0) begin
          du = d0;
          p0 = du * {32'd0, inv};
          if (p0 > ({32'd0, cells} << 32)) return 0;
          c0 = ((p0 >> 32) >= lastc) ? 32'(lastc) : 32'(p0 >> 32);
        end
        c1 = (t1 >= lastc) ? 32'(lastc) : 32'(t1);
      end else if (lo > org) begin
        return 0;
      end
      if (c1 < c0) c1 = c0;
      return 1;
    endfunction

    function void note(grid_req_t r);
      int unsigned cx, cy, x0, x1, y0, y1, x, y, w, full, rem, n;
      bit [63:0] acc[16];
      bit ok;
      answer_word_t aw;
      cx = cols();
      cy = rows(cx);
      case (r.op)
        REQ_INSERT: begin
          if (count < 1024) begin
            x0 = cell_of(r.x0 < r.x1 ? r.x0 : r.x1, ox, ix, cx);
            x1 = cell_of(r.x0 < r.x1 ? r.x1 : r.x0, ox, ix, cx);
            y0 = cell_of(r.y0 < r.y1 ? r.y0 : r.y1, oy, iy, cy);
            y1 = cell_of(r.y0 < r.y1 ? r.y1 : r.y0, oy, iy, cy);
            if (x1 < x0) x1 = x0;
            if (y1 < y0) y1 = y0;
            for (y = y0; y <= y1; y++)
              for (x = x0; x <= x1; x++)
                members[(y * cx + x) * 16 + (count >> 6)][count & 63] = 1'b1;
            count++;
          end
        end
        REQ_QUERY: begin
          foreach (acc[i]) acc[i] = '0;
          ok = count != 0 && span_of(r.x0, r.x1, ox, ix, cx, x0, x1) &&
               span_of(r.y0, r.y1, oy, iy, cy, y0, y1);
          if (ok) begin
            if (longint'(x1 - x0 + 1) * (y1 - y0 + 1) * 4 >= longint'(cx) * cy) begin
              full = count >> 6;
              rem = count & 63;
              for (w = 0; w < full && w < 16; w++) acc[w] = '1;
              if (rem != 0 && full < 16) acc[full] = (64'd1 << rem) - 1;
            end else begin
              for (y = y0; y <= y1; y++)
                for (x = x0; x <= x1; x++)
                  for (w = 0; w < 16; w++) acc[w] |= members[(y * cx + x) * 16 + w];
            end
          end
          n = 0;
          for (w = 0; w < 16; w++)
            if (acc[w] != 0) begin
              aw.word = 4'(w);
              aw.mask = acc[w];
              aw.last = 1'b0;
              answers = {answers, aw};
              n++;
            end
          if (n == 0) begin
            aw.word = 0;
            aw.mask = 0;
            answers = {answers, aw};
          end
          answers[answers.size() - 1].last = 1'b1;
        end
        REQ_CLEAR: begin
          foreach (members[i]) members[i] = '0;
          count = 0;
        end
        default: ;
      endcase
    endfunction

    function void check(bit [3:0] word, bit [63:0] mask, bit last);
      answer_word_t e;
      words_seen++;
      if (answers.size() == 0) begin
        $error("answer word with nothing outstanding: word_index %0d item_mask %h", word, mask);
        errors++;
        return;
      end
      e = answers.pop_front();
      if (e.word != word) begin
        $error("word_index: expected %0d actual %0d", e.word, word);
        errors++;
      end
      if (e.mask != mask) begin
        $error("item_mask: expected %h actual %h", e.mask, mask);
        errors++;
      end
      if (e.last != last) begin
        $error("last: expected %0d actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ugbi_in_if  in_ch();
  ugbi_out_if out_ch();
  ugbi_cfg_if cfg_ch();

  uniform_grid_box_index_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  grid_scoreboard sb = new();
  int burst_left, gap_left, hold_req, hold_cnt, idle_cycles, items_sent, phase_mode;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_INSERT;
    in_ch.coord_x0 = '0;
    in_ch.coord_y0 = '0;
    in_ch.coord_x1 = '0;
    in_ch.coord_y1 = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ORIGIN_X;
    cfg_ch.data = '0;
  end

  // receiver: check at the edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check(out_ch.word_index, out_ch.item_mask, out_ch.last);
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (phase_mode == 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 60000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(bit [2:0] idx, bit [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_grid(bit [31:0] ox, bit [31:0] oy, bit [31:0] ix, bit [31:0] iy,
                          bit [31:0] cx, bit [31:0] cy);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_INV_X, ix);
    write_reg(REG_INV_Y, iy);
    write_reg(REG_CELLS_X, cx);
    write_reg(REG_CELLS_Y, cy);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send(bit [1:0] op, bit [31:0] x0, bit [31:0] y0, bit [31:0] x1, bit [31:0] y1);
    grid_req_t r;
    if (phase_mode != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap_left) @(posedge clk);
        end
      end
      burst_left--;
    end
    r.op = op;
    r.x0 = x0;
    r.y0 = y0;
    r.x1 = x1;
    r.y1 = y1;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= op;
    in_ch.coord_x0 <= x0;
    in_ch.coord_y0 <= y0;
    in_ch.coord_x1 <= x1;
    in_ch.coord_y1 <= y1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note(r);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_coord(bit signed [31:0] org, bit [31:0] inv, int cells);
    longint span, lo, hi;
    if ($urandom_range(0, 7) == 0) return $urandom();
    if (inv == 0) begin
      if ($urandom_range(0, 3) == 0) return org;
      return 32'(longint'(org) + $urandom_range(0, 1 << 21) - (1 << 20));
    end
    span = (longint'(cells) << 32) / inv;
    if (span < 4) span = 4;
    if (span > (longint'(1) << 31)) span = longint'(1) << 31;
    lo = -(span / 4);
    hi = span + span / 4;
    return 32'(longint'(org) + lo + longint'({$urandom(), $urandom()} % (hi - lo + 1)));
  endfunction

  task automatic random_items(int n);
    int cx, cy, k;
    bit [31:0] ax, ay, bx, by, t;
    bit [1:0] op;
    cx = sb.cols();
    cy = sb.rows(cx);
    for (k = 0; k < n; k++) begin
      t = $urandom_range(0, 99);
      op = (t < 50) ? REQ_INSERT : (t < 94) ? REQ_QUERY : (t < 97) ? REQ_CLEAR : 2'd3;
      ax = pick_coord(sb.ox, sb.ix, cx);
      ay = pick_coord(sb.oy, sb.iy, cy);
      bx = pick_coord(sb.ox, sb.ix, cx);
      by = pick_coord(sb.oy, sb.iy, cy);
      if (op == REQ_QUERY && $urandom_range(0, 9) != 0) begin
        if (signed'(bx) < signed'(ax)) {ax, bx} = {bx, ax};
        if (signed'(by) < signed'(ay)) {ay, by} = {by, ay};
        if ($urandom_range(0, 1)) bx = ax + (bx - ax) / $urandom_range(2, 16);
        if ($urandom_range(0, 1)) by = ay + (by - ay) / $urandom_range(2, 16);
      end
      send(op, ax, ay, bx, by);
    end
  endtask

  initial begin
    int k;
    phase_mode = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sb.ix = 0;
    sb.iy = 0;
    sb.ncx = 1;
    sb.ncy = 1;

    // default single-cell grid: empty store, line tests, extremes, ignored type, clear
    send(REQ_QUERY, -1, -1, 1, 1);
    send(REQ_INSERT, 0, 0, 0, 0);
    send(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(REQ_INSERT, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    send(REQ_QUERY, -1, -1, 1, 1);
    send(REQ_QUERY, 1, -1, 5, 1);
    send(REQ_QUERY, -5, -5, -1, -1);
    send(REQ_QUERY, 5, 5, -5, -5);
    send(REQ_QUERY, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send(REQ_CLEAR, 0, 0, 0, 0);
    send(REQ_QUERY, -1, -1, 1, 1);
    drain();

    set_grid(-32'h100000, 32'h20000, 32'h10000, 32'h20000, 16, 16);
    send(REQ_INSERT, 32'h0, 32'h40000, -32'h100000, 32'h20000);
    send(REQ_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send(REQ_INSERT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(REQ_QUERY, -32'hF0000, 32'h28000, -32'hE0000, 32'h30000);
    send(REQ_QUERY, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send(REQ_QUERY, 32'h10000, 32'h20000, 32'h20000, 32'h30000);
    send(REQ_QUERY, 32'h0, 32'h20000, 32'h10000, 32'h20000);
    send(REQ_QUERY, 32'h7FFF0000, 32'h7FFF0000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    drain();

    // fill more than one item word on a single cell
    set_grid(0, 0, 0, 0, 0, 0);
    for (k = 0; k < 70; k++) send(REQ_INSERT, k, k, -k, -k);
    send(REQ_QUERY, -1, -1, 1, 1);
    send(REQ_CLEAR, 0, 0, 0, 0);
    drain();

    phase_mode = 1;
    set_grid(-32'h100000, 32'h20000, 32'h10000, 32'h20000, 16, 16);
    hold_req = 3000;
    random_items(90);
    drain();
    set_grid(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 256, 256);
    random_items(50);
    drain();
    set_grid(32'h30000, -32'h30000, 0, 32'h8000, 0, 511);
    random_items(50);
    drain();
    set_grid(0, 0, 32'h40000, 0, 64, 4);
    random_items(50);
    drain();
    set_grid($urandom(), $urandom(), $urandom_range(1, 32'h80000), $urandom_range(1, 32'h80000),
             $urandom_range(1, 256), $urandom_range(1, 256));
    random_items(50);
    drain();

    $display("run covered %0d requests and %0d answer words over seven grid settings",
             items_sent, sb.words_seen);
    if (sb.errors == 0 && sb.answers.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/ugbi_pkg.sv
design/ugbi_ifs.sv
design/ugbi_ram.sv
design/ugbi_cmd_q.sv
design/ugbi_front.sv
design/ugbi_back.sv
design/uniform_grid_box_index_core.sv
bench/uniform_grid_box_index_core_test.sv
